/* rtl/core/bdrt_pkg.sv */
// Shared types and constants for the button debounce / relay toggle unit.
// No dependencies; used by the top level, bdrt_lane and bdrt_merge.
`default_nettype none

package bdrt_pkg;

    // Default number of button lanes
    localparam int BUTTONS_DEF = 4;

    // Fixed field widths of the stream payload
    localparam int FIELD_BITS = 4;
    localparam int TICK_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // Operation codes carried in s_tuser
    typedef enum logic [1:0] {
        OP_POLL       = 2'd0,
        OP_WRITE_ALL  = 2'd1,
        OP_TOGGLE_ONE = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_BTN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_LOW    = 2'd3;

    // Per-button debounce state
    typedef struct packed {
        logic              last_level;
        logic [TICK_W-1:0] ticks;
        logic              armed;
    } lane_state_t;

    // What one lane found on a poll tick
    typedef struct packed {
        logic              toggle;
        logic              fire;
        logic [HOLD_W-1:0] hold_next;
        logic              long_fired_next;
    } lane_result_t;

    // Merged outcome of one beat
    typedef struct packed {
        logic                  fired;
        logic [FIELD_BITS-1:0] toggled;
        logic [HOLD_W-1:0]     hold_next;
        logic                  long_fired_next;
    } merge_status_t;

endpackage

`default_nettype wire

/* rtl/core/button_debounce_relay_toggle_unit.sv */
// A result beat is registered in the output buffer before it appears on m_tvalid.
// Throughput: one beat per cycle while s_tready is high; all lanes and the merge are combinational.
// A two-entry output buffer keeps s_tready high while one finished result waits.
// Reset (rst_n low, async): relays off, levels released, tick counters at 255,
// no press armed, hold count 0, configuration at defaults (4, 500, 1, 0).
// Top level: instantiates bdrt_lane per button, bdrt_merge, bdrt_obuf; uses bdrt_pkg.
`default_nettype none

module button_debounce_relay_toggle_unit #(
    parameter int BUTTONS = bdrt_pkg::BUTTONS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // button_levels[3:0], relay_values[7:4], relay_index[10:8]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // relay_drive[3:0], relay_states[7:4],
                                        // toggled_mask[11:8], factory_reset[12]
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [bdrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bdrt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // Configuration registers
    logic [bdrt_pkg::TICK_W-1:0] debounce_ticks_reg;
    logic [bdrt_pkg::HOLD_W-1:0] long_press_ticks_reg;
    logic [1:0]                  long_press_button_reg;
    logic                        output_active_low_reg;

    // Block state
    bdrt_pkg::lane_state_t [BUTTONS-1:0] lane_reg, lane_next;
    logic [BUTTONS-1:0]                  relay_on_reg, relay_on_next;
    logic [bdrt_pkg::HOLD_W-1:0]         hold_count_reg;
    logic                                long_fired_reg;

    bdrt_pkg::lane_result_t [BUTTONS-1:0] lane_res;
    bdrt_pkg::merge_status_t              status;

    logic [3:0] button_levels;
    logic [3:0] relay_values;
    logic [2:0] relay_index;
    logic [1:0] operation;
    logic       accept;
    logic       poll;
    logic [3:0] states4;
    logic [3:0] drive4;
    logic [15:0] result_data;

    assign button_levels = s_tdata[3:0];
    assign relay_values  = s_tdata[7:4];
    assign relay_index   = s_tdata[10:8];
    assign operation     = s_tuser;
    assign accept        = s_tvalid && s_tready;
    assign poll          = (operation == bdrt_pkg::OP_POLL);

    // Button lanes
    for (genvar i = 0; i < BUTTONS; i++)
    begin : g_lane
        logic level;
        if (i < bdrt_pkg::FIELD_BITS)
        begin : g_in
            assign level = button_levels[i % bdrt_pkg::FIELD_BITS];
        end
        else
        begin : g_hi
            assign level = 1'b1;
        end

        bdrt_lane u_lane (
            .level            (level),
            .state            (lane_reg[i]),
            .is_lp            (int'(long_press_button_reg) == i),
            .hold_count       (hold_count_reg),
            .long_fired       (long_fired_reg),
            .debounce_ticks   (debounce_ticks_reg),
            .long_press_ticks (long_press_ticks_reg),
            .state_next       (lane_next[i]),
            .result           (lane_res[i])
        );
    end

    // Merge of lane findings and operation
    bdrt_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .operation         (operation),
        .relay_values      (relay_values),
        .relay_index       (relay_index),
        .long_press_button (long_press_button_reg),
        .relay_on          (relay_on_reg),
        .hold_count        (hold_count_reg),
        .long_fired        (long_fired_reg),
        .lane_res          (lane_res),
        .relay_next        (relay_on_next),
        .status            (status)
    );

    // Result packing
    always_comb
    begin
        states4 = '0;
        for (int i = 0; i < bdrt_pkg::FIELD_BITS; i++)
        begin
            if (i < BUTTONS)
            begin
                states4[i] = relay_on_next[i % BUTTONS];
            end
        end
        drive4      = states4 ^ {4{output_active_low_reg}};
        result_data = {3'b000, status.fired, status.toggled, states4, drive4};
    end

    bdrt_obuf #(
        .W (16)
    ) u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg    <= 8'd4;
            long_press_ticks_reg  <= 16'd500;
            long_press_button_reg <= 2'd1;
            output_active_low_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdrt_pkg::CFG_DEBOUNCE:   debounce_ticks_reg    <= cfg_wdata[7:0];
                bdrt_pkg::CFG_LONG_TICKS: long_press_ticks_reg  <= cfg_wdata[15:0];
                bdrt_pkg::CFG_LONG_BTN:   long_press_button_reg <= cfg_wdata[1:0];
                bdrt_pkg::CFG_ACT_LOW:    output_active_low_reg <= cfg_wdata[0];
                default:                  debounce_ticks_reg    <= debounce_ticks_reg;
            endcase
        end
    end

    // Block state update on each accepted beat; lane and long-press state only on polls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUTTONS; i++)
            begin
                lane_reg[i].last_level <= 1'b1;
                lane_reg[i].ticks      <= bdrt_pkg::TICK_MAX;
                lane_reg[i].armed      <= 1'b0;
            end
            relay_on_reg   <= '0;
            hold_count_reg <= '0;
            long_fired_reg <= 1'b0;
        end
        else if (accept)
        begin
            relay_on_reg <= relay_on_next;
            if (poll)
            begin
                lane_reg       <= lane_next;
                hold_count_reg <= status.hold_next;
                long_fired_reg <= status.long_fired_next;
            end
        end
    end

    // A firing long press leaves the fired flag set
    a_fire_sets_flag : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.fired) |=> long_fired_reg)
        else $error("long press fired but flag not set");

    // A level change on an accepted poll restarts lane 0's counter
    a_change_clears_ticks : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && poll && (button_levels[0] != lane_reg[0].last_level))
        |=> (lane_reg[0].ticks == '0))
        else $error("tick counter not cleared on level change");

    // A fired long press never coexists with a set flag beforehand
    a_fire_once : assert property (@(posedge clk) disable iff (!rst_n)
        status.fired |-> !long_fired_reg)
        else $error("long press fired twice");

    // Non-poll beats report no toggles and no pulse
    a_nonpoll_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        !poll |-> (status.toggled == '0) && !status.fired)
        else $error("non-poll beat reported press activity");

endmodule

`default_nettype wire

/* rtl/core/bdrt_lane.sv */
// One button lane: debounce counter, press arming, short/long press decision.
// Depends on bdrt_pkg.
`default_nettype none

module bdrt_lane (
    input  wire logic                         level,
    input  wire bdrt_pkg::lane_state_t        state,
    input  wire logic                         is_lp,
    input  wire logic [bdrt_pkg::HOLD_W-1:0]  hold_count,
    input  wire logic                         long_fired,
    input  wire logic [bdrt_pkg::TICK_W-1:0]  debounce_ticks,
    input  wire logic [bdrt_pkg::HOLD_W-1:0]  long_press_ticks,
    output bdrt_pkg::lane_state_t             state_next,
    output bdrt_pkg::lane_result_t            result
);

    logic                        changed;
    logic [bdrt_pkg::TICK_W-1:0] ticks_next;
    logic                        stable;

    // Tick counter since last level change, saturating
    always_comb
    begin
        changed = (level != state.last_level);
        if (changed)
        begin
            ticks_next = '0;
        end
        else if (state.ticks != bdrt_pkg::TICK_MAX)
        begin
            ticks_next = state.ticks + bdrt_pkg::TICK_W'(1);
        end
        else
        begin
            ticks_next = state.ticks;
        end
        stable = (ticks_next > debounce_ticks);
    end

    // Press / release handling once the level is stable
    always_comb
    begin
        state_next.last_level  = level;
        state_next.ticks       = ticks_next;
        state_next.armed       = state.armed;
        result.toggle          = 1'b0;
        result.fire            = 1'b0;
        result.hold_next       = hold_count;
        result.long_fired_next = long_fired;
        if (stable)
        begin
            if (!level)
            begin
                if (!state.armed)
                begin
                    state_next.armed = 1'b1;
                    if (is_lp)
                    begin
                        result.hold_next = '0;
                    end
                end
                else if (is_lp && (hold_count != bdrt_pkg::HOLD_MAX))
                begin
                    result.hold_next = hold_count + bdrt_pkg::HOLD_W'(1);
                end
                if (is_lp && !long_fired && (result.hold_next >= long_press_ticks))
                begin
                    result.fire            = 1'b1;
                    result.long_fired_next = 1'b1;
                end
            end
            else
            begin
                // a release after a fired long press toggles nothing
                result.toggle    = state.armed && !(is_lp && long_fired);
                state_next.armed = 1'b0;
                if (is_lp)
                begin
                    result.long_fired_next = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bdrt_merge.sv */
// Merge stage: combines lane findings with the operation into new relay bits,
// the shared long-press state and the reported masks. Depends on bdrt_pkg.
`default_nettype none

module bdrt_merge #(
    parameter int BUTTONS = bdrt_pkg::BUTTONS_DEF
) (
    input  wire logic [1:0]                          operation,
    input  wire logic [bdrt_pkg::FIELD_BITS-1:0]     relay_values,
    input  wire logic [2:0]                          relay_index,
    input  wire logic [1:0]                          long_press_button,
    input  wire logic [BUTTONS-1:0]                  relay_on,
    input  wire logic [bdrt_pkg::HOLD_W-1:0]         hold_count,
    input  wire logic                                long_fired,
    input  wire bdrt_pkg::lane_result_t [BUTTONS-1:0] lane_res,
    output logic [BUTTONS-1:0]                       relay_next,
    output bdrt_pkg::merge_status_t                  status
);

    logic [BUTTONS-1:0]              toggles;
    logic                            fired;
    logic [bdrt_pkg::HOLD_W-1:0]     hold_sel;
    logic                            lf_sel;
    logic                            fired_out;
    logic [bdrt_pkg::FIELD_BITS-1:0] toggled_out;

    // Pick the long-press lane's view of the shared state
    always_comb
    begin
        fired    = 1'b0;
        hold_sel = hold_count;
        lf_sel   = long_fired;
        for (int i = 0; i < BUTTONS; i++)
        begin
            toggles[i] = lane_res[i].toggle;
            if (int'(long_press_button) == i)
            begin
                fired    = lane_res[i].fire;
                hold_sel = lane_res[i].hold_next;
                lf_sel   = lane_res[i].long_fired_next;
            end
        end
    end

    // New relay bits per operation
    always_comb
    begin
        relay_next  = relay_on;
        fired_out   = 1'b0;
        toggled_out = '0;
        case (operation)
            bdrt_pkg::OP_POLL:
            begin
                fired_out = fired;
                for (int j = 0; j < BUTTONS; j++)
                begin
                    if (j < bdrt_pkg::FIELD_BITS)
                    begin
                        toggled_out[j] = toggles[j];
                    end
                    // a long press clears all; only higher lanes toggle after it
                    if (fired)
                    begin
                        relay_next[j] = (j > int'(long_press_button)) && toggles[j];
                    end
                    else
                    begin
                        relay_next[j] = relay_on[j] ^ toggles[j];
                    end
                end
            end
            bdrt_pkg::OP_WRITE_ALL:
            begin
                for (int j = 0; j < BUTTONS; j++)
                begin
                    relay_next[j] = (j < bdrt_pkg::FIELD_BITS) ?
                                    relay_values[j % bdrt_pkg::FIELD_BITS] : 1'b0;
                end
            end
            bdrt_pkg::OP_TOGGLE_ONE:
            begin
                for (int j = 0; j < BUTTONS; j++)
                begin
                    if ((int'(relay_index) == j) && (j < bdrt_pkg::FIELD_BITS))
                    begin
                        relay_next[j] = !relay_on[j];
                    end
                end
            end
            default:
            begin
                relay_next = relay_on;
            end
        endcase
    end

    // Collected status of the beat
    assign status = '{fired: fired_out, toggled: toggled_out,
                      hold_next: hold_sel, long_fired_next: lf_sel};

endmodule

`default_nettype wire

/* rtl/core/bdrt_obuf.sv */
// Two-entry output buffer (main register plus skid register) for result beats.
// Depends on nothing else.
`default_nettype none

module bdrt_obuf #(
    parameter int W = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic         main_valid_reg, main_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    logic [W-1:0] main_data_reg, main_data_next;
    logic [W-1:0] skid_data_reg, skid_data_next;
    logic         push;
    logic         pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;

    // Next-state of the two entries
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_data_next = in_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_data_next  = in_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire
